// File: hw/rtl/psl_pkg.sv
// ----------------------------------------------------------------------------
// psl_pkg
// Shared types and constants of the pot smoothing, lock and led mapper.
// ----------------------------------------------------------------------------
package psl_pkg;

  localparam int unsigned WINDOW_DEF   = 10;
  localparam int unsigned ADC_BITS_DEF = 10;

  localparam int unsigned MODE_W  = 2;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned DATA_W  = 16;
  localparam int unsigned LOCK_W  = 16;
  localparam int unsigned DLT_W   = 10;
  localparam int unsigned OFS_W   = 10;
  localparam int unsigned IDLE_W  = 17;
  localparam int unsigned LVL_W   = 8;
  localparam int unsigned AVG_O_W = 10;

  localparam logic [LOCK_W-1:0] LOCK_TIME_RST    = 16'd5000;
  localparam logic [DLT_W-1:0]  UNLOCK_DELTA_RST = 10'd30;
  localparam logic [DLT_W-1:0]  UPDATE_DELTA_RST = 10'd3;
  localparam logic [OFS_W-1:0]  REV_OFS_RST      = 10'd0;

  localparam int unsigned COLD_LO = 50;
  localparam int unsigned WARM_HI = 900;
  localparam int unsigned LVL_MAX = 255;
  localparam int unsigned SPAN_CW = 425;
  localparam int unsigned SPAN_BR = 850;

  typedef enum logic [MODE_W-1:0] {
    MODE_SCAN = 2'd0,
    MODE_TICK = 2'd1,
    MODE_LOCK = 2'd2
  } mode_t;

  typedef enum logic [IDX_W-1:0] {
    REG_LOCK_TIME    = 3'd0,
    REG_UNLOCK_DELTA = 3'd1,
    REG_UPDATE_DELTA = 3'd2,
    REG_REV_OFS_A    = 3'd3,
    REG_REV_OFS_B    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic written;
    logic locked;
  } flags_t;

endpackage

// File: hw/rtl/psl_ram.sv
// ----------------------------------------------------------------------------
// psl_ram
// Generic single write port ram with one registered read port.
// ----------------------------------------------------------------------------
module psl_ram #(
  parameter int unsigned WIDTH = 20,
  parameter int unsigned DEPTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/psl_core.sv
// ----------------------------------------------------------------------------
// psl_core
// Input register, moving average over the sample ring, lock and hold logic.
// ----------------------------------------------------------------------------
module psl_core #(
  parameter int unsigned WINDOW   = psl_pkg::WINDOW_DEF,
  parameter int unsigned ADC_BITS = psl_pkg::ADC_BITS_DEF,
  localparam int unsigned SMP_W   = (ADC_BITS > psl_pkg::OFS_W) ? ADC_BITS : psl_pkg::OFS_W
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [psl_pkg::MODE_W-1:0]           mode,
  input  logic [ADC_BITS-1:0]                  pot_a,
  input  logic [ADC_BITS-1:0]                  pot_b,
  input  logic [psl_pkg::LOCK_W-1:0]           lock_time,
  input  logic [psl_pkg::DLT_W-1:0]            unlock_delta,
  input  logic [psl_pkg::DLT_W-1:0]            update_delta,
  input  logic [psl_pkg::OFS_W-1:0]            rev_ofs_a,
  input  logic [psl_pkg::OFS_W-1:0]            rev_ofs_b,
  output logic                                 m_valid,
  input  logic                                 m_ready,
  output psl_pkg::flags_t                      m_flags,
  output logic [SMP_W-1:0]                     m_held_a,
  output logic [SMP_W-1:0]                     m_held_b,
  output logic [SMP_W-1:0]                     m_avg_a,
  output logic [SMP_W-1:0]                     m_avg_b
);

  localparam int unsigned SLOT_W = $clog2(WINDOW);
  localparam int unsigned SUM_W  = SMP_W + $clog2(WINDOW);
  localparam int unsigned N_W    = SUM_W + 1;
  localparam int unsigned AVG_K  = N_W + $clog2(WINDOW);
  localparam int unsigned PROD_W = N_W + AVG_K;
  localparam longint unsigned AVG_M = ((longint'(1) << AVG_K) + WINDOW - 1) / WINDOW;
  localparam int unsigned IDLE_W = psl_pkg::IDLE_W;

  logic                  s1_vld;
  psl_pkg::mode_t        s1_mode;
  logic [SMP_W-1:0]      s1_pa;
  logic [SMP_W-1:0]      s1_pb;

  logic [SLOT_W-1:0]     slot;
  logic [SLOT_W-1:0]     slot_next;
  logic [SLOT_W-1:0]     slot_inc;
  logic [SUM_W-1:0]      sum_a;
  logic [SUM_W-1:0]      sum_b;
  logic [SUM_W-1:0]      sum_a_next;
  logic [SUM_W-1:0]      sum_b_next;
  logic [SUM_W-1:0]      sum_a_scan;
  logic [SUM_W-1:0]      sum_b_scan;
  logic [SMP_W-1:0]      held_a;
  logic [SMP_W-1:0]      held_b;
  logic [SMP_W-1:0]      held_a_next;
  logic [SMP_W-1:0]      held_b_next;
  logic                  lock_q;
  logic                  lock_next;
  logic [IDLE_W-1:0]     idle_q;
  logic [IDLE_W-1:0]     idle_next;
  logic [WINDOW-1:0]     vmask;
  logic                  rd_ok;

  logic [SMP_W-1:0]      pa_in;
  logic [SMP_W-1:0]      pb_in;
  logic [SMP_W-1:0]      ofs_a;
  logic [SMP_W-1:0]      ofs_b;
  logic [SMP_W-1:0]      pa_rev;
  logic [SMP_W-1:0]      pb_rev;

  logic                  m_free;
  logic                  s1_go;
  logic                  is_scan;
  logic                  we;
  logic [SLOT_W-1:0]     rd_addr;
  logic [2*SMP_W-1:0]    rd_data;
  logic [SMP_W-1:0]      old_a;
  logic [SMP_W-1:0]      old_b;
  logic [N_W-1:0]        n_a;
  logic [N_W-1:0]        n_b;
  logic [PROD_W-1:0]     prod_a;
  logic [PROD_W-1:0]     prod_b;
  logic [SMP_W-1:0]      avg_a;
  logic [SMP_W-1:0]      avg_b;
  logic [SMP_W-1:0]      dif_a;
  logic [SMP_W-1:0]      dif_b;
  logic                  jump;
  logic                  lock_scan;
  logic                  upd;

  // input side: optional reversal against offset
  assign pa_in  = SMP_W'(pot_a);
  assign pb_in  = SMP_W'(pot_b);
  assign ofs_a  = SMP_W'(rev_ofs_a);
  assign ofs_b  = SMP_W'(rev_ofs_b);
  assign pa_rev = (rev_ofs_a == '0) ? pa_in :
                  (pa_in > ofs_a) ? (pa_in - ofs_a) : (ofs_a - pa_in);
  assign pb_rev = (rev_ofs_b == '0) ? pb_in :
                  (pb_in > ofs_b) ? (pb_in - ofs_b) : (ofs_b - pb_in);

  assign m_free   = !m_valid || m_ready;
  assign s1_go    = s1_vld && m_free;
  assign in_ready = !s1_vld || m_free;
  assign is_scan  = (s1_mode == psl_pkg::MODE_SCAN);
  assign we       = s1_go && is_scan;

  // read ahead: the ring entry of the next slot is ready for the next beat
  assign slot_inc = (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + 1'b1;
  assign rd_addr  = we ? slot_inc : slot;

  psl_ram #(
    .WIDTH (2 * SMP_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (we),
    .waddr (slot),
    .wdata ({s1_pa, s1_pb}),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign old_a = rd_ok ? rd_data[2*SMP_W-1:SMP_W] : '0;
  assign old_b = rd_ok ? rd_data[SMP_W-1:0] : '0;

  always_comb begin
    sum_a_scan = sum_a - SUM_W'(old_a) + SUM_W'(s1_pa);
    sum_b_scan = sum_b - SUM_W'(old_b) + SUM_W'(s1_pb);
    n_a        = N_W'(sum_a_scan) + N_W'(WINDOW / 2);
    n_b        = N_W'(sum_b_scan) + N_W'(WINDOW / 2);
    prod_a     = PROD_W'(n_a) * PROD_W'(AVG_M);
    prod_b     = PROD_W'(n_b) * PROD_W'(AVG_M);
    avg_a      = prod_a[AVG_K +: SMP_W];
    avg_b      = prod_b[AVG_K +: SMP_W];
    dif_a      = (held_a > avg_a) ? (held_a - avg_a) : (avg_a - held_a);
    dif_b      = (held_b > avg_b) ? (held_b - avg_b) : (avg_b - held_b);
    jump       = (dif_a > SMP_W'(unlock_delta)) || (dif_b > SMP_W'(unlock_delta));
    lock_scan  = (lock_q || (idle_q > IDLE_W'(lock_time))) && !jump;
    upd        = !lock_scan &&
                 ((dif_a > SMP_W'(update_delta)) || (dif_b > SMP_W'(update_delta)));
  end

  always_comb begin
    slot_next   = slot;
    sum_a_next  = sum_a;
    sum_b_next  = sum_b;
    held_a_next = held_a;
    held_b_next = held_b;
    lock_next   = lock_q;
    idle_next   = idle_q;
    if (s1_go) begin
      unique case (s1_mode)
        psl_pkg::MODE_SCAN: begin
          slot_next  = slot_inc;
          sum_a_next = sum_a_scan;
          sum_b_next = sum_b_scan;
          lock_next  = lock_scan;
          if (jump) begin
            idle_next = '0;
          end
          if (upd) begin
            held_a_next = avg_a;
            held_b_next = avg_b;
          end
        end
        psl_pkg::MODE_TICK: begin
          if (idle_q != '1) begin
            idle_next = idle_q + 1'b1;
          end
        end
        psl_pkg::MODE_LOCK: begin
          lock_next = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld  <= 1'b0;
      m_valid <= 1'b0;
      slot    <= '0;
      sum_a   <= '0;
      sum_b   <= '0;
      held_a  <= '0;
      held_b  <= '0;
      lock_q  <= 1'b0;
      idle_q  <= '0;
      vmask   <= '0;
      rd_ok   <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_vld <= in_valid;
      end
      if (m_free) begin
        m_valid <= we;
      end
      slot   <= slot_next;
      sum_a  <= sum_a_next;
      sum_b  <= sum_b_next;
      held_a <= held_a_next;
      held_b <= held_b_next;
      lock_q <= lock_next;
      idle_q <= idle_next;
      if (we) begin
        vmask[slot] <= 1'b1;
      end
      rd_ok <= vmask[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mode <= psl_pkg::mode_t'(mode);
      s1_pa   <= pa_rev;
      s1_pb   <= pb_rev;
    end
    if (we) begin
      m_flags.written <= upd;
      m_flags.locked  <= lock_scan;
      m_held_a        <= held_a_next;
      m_held_b        <= held_b_next;
      m_avg_a         <= avg_a;
      m_avg_b         <= avg_b;
    end
  end

`ifndef SYNTHESIS
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, slot} < (SLOT_W + 1)'(WINDOW))
    else $error("ring slot out of range");

  a_write_unlocked: assert property (@(posedge clk) disable iff (rst)
    m_valid && m_flags.written |-> !m_flags.locked)
    else $error("levels issued while locked");

  a_tick_counts: assert property (@(posedge clk) disable iff (rst)
    s1_go && (s1_mode == psl_pkg::MODE_TICK) |=> (idle_q != '0))
    else $error("tick did not advance idle timer");

  a_force_lock: assert property (@(posedge clk) disable iff (rst)
    s1_go && (s1_mode == psl_pkg::MODE_LOCK) |=> lock_q)
    else $error("force lock beat did not lock");
`endif

endmodule

// File: hw/rtl/psl_map.sv
// ----------------------------------------------------------------------------
// psl_map
// Maps held averages to cold, warm and brightness levels; result register.
// ----------------------------------------------------------------------------
module psl_map #(
  parameter int unsigned ADC_BITS = psl_pkg::ADC_BITS_DEF,
  localparam int unsigned SMP_W   = (ADC_BITS > psl_pkg::OFS_W) ? ADC_BITS : psl_pkg::OFS_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          m_valid,
  output logic                          m_ready,
  input  psl_pkg::flags_t               m_flags,
  input  logic [SMP_W-1:0]              m_held_a,
  input  logic [SMP_W-1:0]              m_held_b,
  input  logic [SMP_W-1:0]              m_avg_a,
  input  logic [SMP_W-1:0]              m_avg_b,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          led_written,
  output logic [psl_pkg::LVL_W-1:0]     cold_level,
  output logic [psl_pkg::LVL_W-1:0]     warm_level,
  output logic [psl_pkg::LVL_W-1:0]     brightness,
  output logic                          is_locked,
  output logic [psl_pkg::AVG_O_W-1:0]   avg_a,
  output logic [psl_pkg::AVG_O_W-1:0]   avg_b
);

  localparam int unsigned MAP_K = SMP_W + 10;
  localparam int unsigned MP_W  = SMP_W + MAP_K;
  localparam longint unsigned M_CW =
    ((longint'(psl_pkg::LVL_MAX) << MAP_K) + psl_pkg::SPAN_CW - 1) / psl_pkg::SPAN_CW;
  localparam longint unsigned M_BR =
    ((longint'(psl_pkg::LVL_MAX) << MAP_K) + psl_pkg::SPAN_BR - 1) / psl_pkg::SPAN_BR;

  logic [SMP_W-1:0]           d_cold;
  logic [SMP_W-1:0]           d_warm;
  logic [SMP_W-1:0]           d_br;
  logic [psl_pkg::LVL_W-1:0]  lvl_cold;
  logic [psl_pkg::LVL_W-1:0]  lvl_warm;
  logic [psl_pkg::LVL_W-1:0]  lvl_br;

  function automatic logic [psl_pkg::LVL_W-1:0] scale(input logic [SMP_W-1:0] d,
                                                        input logic [MAP_K-1:0] m);
    logic [MP_W-1:0]  p;
    logic [SMP_W-1:0] q;
    p = MP_W'(d) * MP_W'(m);
    q = p[MP_W-1:MAP_K];
    return (q > SMP_W'(psl_pkg::LVL_MAX)) ? psl_pkg::LVL_W'(psl_pkg::LVL_MAX)
                                          : q[psl_pkg::LVL_W-1:0];
  endfunction

  assign m_ready = !out_valid || out_ready;

  always_comb begin
    d_cold   = (m_held_a > SMP_W'(psl_pkg::COLD_LO)) ?
               (m_held_a - SMP_W'(psl_pkg::COLD_LO)) : '0;
    d_warm   = (m_held_a < SMP_W'(psl_pkg::WARM_HI)) ?
               (SMP_W'(psl_pkg::WARM_HI) - m_held_a) : '0;
    d_br     = (m_held_b > SMP_W'(psl_pkg::COLD_LO)) ?
               (m_held_b - SMP_W'(psl_pkg::COLD_LO)) : '0;
    lvl_cold = scale(d_cold, MAP_K'(M_CW));
    lvl_warm = scale(d_warm, MAP_K'(M_CW));
    lvl_br   = scale(d_br, MAP_K'(M_BR));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (m_ready) begin
      out_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (m_valid && m_ready) begin
      led_written <= m_flags.written;
      is_locked   <= m_flags.locked;
      cold_level  <= lvl_cold;
      warm_level  <= lvl_warm;
      brightness  <= lvl_br;
      avg_a       <= psl_pkg::AVG_O_W'(m_avg_a);
      avg_b       <= psl_pkg::AVG_O_W'(m_avg_b);
    end
  end

endmodule

// File: hw/rtl/pot_smoothing_lock_led_mapper_top.sv
// ----------------------------------------------------------------------------
// pot_smoothing_lock_led_mapper_top
// Pot smoothing, idle lock and led level mapper with its register file.
// ----------------------------------------------------------------------------
// Takes one beat per clock while the result side keeps up: a scan beat gives
// one result beat, tick and force lock beats give none. There are three register
// stages: the input register, the averaging and lock stage (ring ram read one
// slot ahead, running sums, one reciprocal multiply per channel) and the level
// map stage into the result register. The sample ring is a WINDOW deep ram whose
// entries read as zero until first written, so no clearing pass follows reset.
// Registers are written through the cfg channel, which is always ready; the user
// must write them only while the block is idle, which the block does not enforce.
module pot_smoothing_lock_led_mapper_top #(
  parameter int unsigned WINDOW   = psl_pkg::WINDOW_DEF,
  parameter int unsigned ADC_BITS = psl_pkg::ADC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [psl_pkg::IDX_W-1:0]     cfg_index,
  input  logic [psl_pkg::DATA_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [psl_pkg::MODE_W-1:0]    mode,
  input  logic [ADC_BITS-1:0]           pot_a,
  input  logic [ADC_BITS-1:0]           pot_b,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          led_written,
  output logic [psl_pkg::LVL_W-1:0]     cold_level,
  output logic [psl_pkg::LVL_W-1:0]     warm_level,
  output logic [psl_pkg::LVL_W-1:0]     brightness,
  output logic                          is_locked,
  output logic [psl_pkg::AVG_O_W-1:0]   avg_a,
  output logic [psl_pkg::AVG_O_W-1:0]   avg_b
);

  localparam int unsigned SMP_W = (ADC_BITS > psl_pkg::OFS_W) ? ADC_BITS : psl_pkg::OFS_W;

  logic [psl_pkg::LOCK_W-1:0] lock_time;
  logic [psl_pkg::DLT_W-1:0]  unlock_delta;
  logic [psl_pkg::DLT_W-1:0]  update_delta;
  logic [psl_pkg::OFS_W-1:0]  rev_ofs_a;
  logic [psl_pkg::OFS_W-1:0]  rev_ofs_b;

  logic                       m_valid;
  logic                       m_ready;
  psl_pkg::flags_t            m_flags;
  logic [SMP_W-1:0]           m_held_a;
  logic [SMP_W-1:0]           m_held_b;
  logic [SMP_W-1:0]           m_avg_a;
  logic [SMP_W-1:0]           m_avg_b;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_time    <= psl_pkg::LOCK_TIME_RST;
      unlock_delta <= psl_pkg::UNLOCK_DELTA_RST;
      update_delta <= psl_pkg::UPDATE_DELTA_RST;
      rev_ofs_a    <= psl_pkg::REV_OFS_RST;
      rev_ofs_b    <= psl_pkg::REV_OFS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (psl_pkg::reg_idx_t'(cfg_index))
        psl_pkg::REG_LOCK_TIME:    lock_time    <= cfg_data[psl_pkg::LOCK_W-1:0];
        psl_pkg::REG_UNLOCK_DELTA: unlock_delta <= cfg_data[psl_pkg::DLT_W-1:0];
        psl_pkg::REG_UPDATE_DELTA: update_delta <= cfg_data[psl_pkg::DLT_W-1:0];
        psl_pkg::REG_REV_OFS_A:    rev_ofs_a    <= cfg_data[psl_pkg::OFS_W-1:0];
        psl_pkg::REG_REV_OFS_B:    rev_ofs_b    <= cfg_data[psl_pkg::OFS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  psl_core #(
    .WINDOW   (WINDOW),
    .ADC_BITS (ADC_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .pot_a        (pot_a),
    .pot_b        (pot_b),
    .lock_time    (lock_time),
    .unlock_delta (unlock_delta),
    .update_delta (update_delta),
    .rev_ofs_a    (rev_ofs_a),
    .rev_ofs_b    (rev_ofs_b),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_flags      (m_flags),
    .m_held_a     (m_held_a),
    .m_held_b     (m_held_b),
    .m_avg_a      (m_avg_a),
    .m_avg_b      (m_avg_b)
  );

  psl_map #(
    .ADC_BITS (ADC_BITS)
  ) u_map (
    .clk         (clk),
    .rst         (rst),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_flags     (m_flags),
    .m_held_a    (m_held_a),
    .m_held_b    (m_held_b),
    .m_avg_a     (m_avg_a),
    .m_avg_b     (m_avg_b),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .led_written (led_written),
    .cold_level  (cold_level),
    .warm_level  (warm_level),
    .brightness  (brightness),
    .is_locked   (is_locked),
    .avg_a       (avg_a),
    .avg_b       (avg_b)
  );

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the pot smoothing, idle lock and led level mapper. Scan, tick and
// force lock beats go in through the input channel and registers through the
// cfg channel. An in-bench model of the averaging rings, the idle lock and the
// level maps predicts every result beat, and the result side checks each
// field in order. Both sides idle and stall at random; one long result stall
// fills the block and backs up its input.
// ----------------------------------------------------------------------------
module testbench;
  import psl_pkg::*;

  localparam int unsigned WIN = WINDOW_DEF;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic [IDX_W-1:0] REG_NONE = 3'd7;
  localparam logic [IDLE_W-1:0] IDLE_TOP = 17'h1FFFF;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 4;

  typedef struct packed {
    logic written;
    logic [LVL_W-1:0] cold;
    logic [LVL_W-1:0] warm;
    logic [LVL_W-1:0] bright;
    logic locked;
    logic [AVG_O_W-1:0] mean_a;
    logic [AVG_O_W-1:0] mean_b;
  } scan_levels_t;

  logic clk;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [MODE_W-1:0] mode;
  logic [ADC_BITS_DEF-1:0] pot_a;
  logic [ADC_BITS_DEF-1:0] pot_b;
  logic out_valid;
  logic out_ready;
  logic led_written;
  logic [LVL_W-1:0] cold_level;
  logic [LVL_W-1:0] warm_level;
  logic [LVL_W-1:0] brightness;
  logic is_locked;
  logic [AVG_O_W-1:0] avg_a;
  logic [AVG_O_W-1:0] avg_b;

  // model state
  logic [LOCK_W-1:0] set_lock_time;
  logic [DLT_W-1:0] set_unlock;
  logic [DLT_W-1:0] set_update;
  logic [OFS_W-1:0] set_ofs_a;
  logic [OFS_W-1:0] set_ofs_b;
  logic [ADC_BITS_DEF-1:0] samples_a [WIN];
  logic [ADC_BITS_DEF-1:0] samples_b [WIN];
  logic [13:0] total_a;
  logic [13:0] total_b;
  int unsigned ring_slot;
  logic [ADC_BITS_DEF-1:0] kept_a;
  logic [ADC_BITS_DEF-1:0] kept_b;
  logic lock_state;
  logic [IDLE_W-1:0] idle_count;

  scan_levels_t expected_scans[$];
  int mismatches;
  int quiet_cycles;
  bit tx_gapless;
  bit rx_gapless;
  int unsigned rx_hold;

  pot_smoothing_lock_led_mapper_top uut (.*);

  always #6 clk = ~clk;

  function automatic int abs_diff(input int x, input int y);
    return x > y ? x - y : y - x;
  endfunction

  function automatic logic [LVL_W-1:0] clamp_level(input int v);
    return (v > int'(LVL_MAX)) ? LVL_W'(LVL_MAX) : LVL_W'(v);
  endfunction

  function automatic scan_levels_t levels_of(input logic [ADC_BITS_DEF-1:0] ha,
                                             input logic [ADC_BITS_DEF-1:0] hb);
    scan_levels_t r;
    r = '0;
    r.cold = (ha <= COLD_LO) ? '0 : clamp_level((int'(ha) - COLD_LO) * LVL_MAX / SPAN_CW);
    r.warm = (ha >= WARM_HI) ? '0 : clamp_level((WARM_HI - int'(ha)) * LVL_MAX / SPAN_CW);
    r.bright = (hb <= COLD_LO) ? '0 : clamp_level((int'(hb) - COLD_LO) * LVL_MAX / SPAN_BR);
    return r;
  endfunction

  function automatic void reset_model();
    set_lock_time = LOCK_TIME_RST;
    set_unlock = UNLOCK_DELTA_RST;
    set_update = UPDATE_DELTA_RST;
    set_ofs_a = REV_OFS_RST;
    set_ofs_b = REV_OFS_RST;
    for (int k = 0; k < WIN; k++) begin
      samples_a[k] = '0;
      samples_b[k] = '0;
    end
    total_a = '0;
    total_b = '0;
    ring_slot = 0;
    kept_a = '0;
    kept_b = '0;
    lock_state = 1'b0;
    idle_count = '0;
  endfunction

  function automatic void store_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    case (idx)
      REG_LOCK_TIME: set_lock_time = data;
      REG_UNLOCK_DELTA: set_unlock = data[DLT_W-1:0];
      REG_UPDATE_DELTA: set_update = data[DLT_W-1:0];
      REG_REV_OFS_A: set_ofs_a = data[OFS_W-1:0];
      REG_REV_OFS_B: set_ofs_b = data[OFS_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void smooth_scan(input logic [ADC_BITS_DEF-1:0] raw_a,
                                      input logic [ADC_BITS_DEF-1:0] raw_b);
    logic [ADC_BITS_DEF-1:0] sa;
    logic [ADC_BITS_DEF-1:0] sb;
    logic [AVG_O_W-1:0] ma;
    logic [AVG_O_W-1:0] mb;
    logic wrote;
    scan_levels_t r;
    sa = (set_ofs_a != 0) ? ADC_BITS_DEF'(abs_diff(raw_a, set_ofs_a)) : raw_a;
    sb = (set_ofs_b != 0) ? ADC_BITS_DEF'(abs_diff(raw_b, set_ofs_b)) : raw_b;
    total_a = total_a - samples_a[ring_slot] + sa;
    total_b = total_b - samples_b[ring_slot] + sb;
    samples_a[ring_slot] = sa;
    samples_b[ring_slot] = sb;
    ring_slot = (ring_slot + 1 >= WIN) ? 0 : ring_slot + 1;
    ma = AVG_O_W'((int'(total_a) + WIN / 2) / WIN);
    mb = AVG_O_W'((int'(total_b) + WIN / 2) / WIN);
    wrote = 1'b0;
    if (idle_count > set_lock_time) lock_state = 1'b1;
    if (abs_diff(kept_a, ma) > set_unlock || abs_diff(kept_b, mb) > set_unlock) begin
      lock_state = 1'b0;
      idle_count = '0;
    end
    if (!lock_state && (abs_diff(kept_a, ma) > set_update ||
                        abs_diff(kept_b, mb) > set_update)) begin
      kept_a = ma;
      kept_b = mb;
      wrote = 1'b1;
    end
    r = levels_of(kept_a, kept_b);
    r.written = wrote;
    r.locked = lock_state;
    r.mean_a = ma;
    r.mean_b = mb;
    expected_scans.push_back(r);
  endfunction

  function automatic void predict_beat(input logic [MODE_W-1:0] code,
                                       input logic [ADC_BITS_DEF-1:0] a,
                                       input logic [ADC_BITS_DEF-1:0] b);
    case (code)
      MODE_SCAN: smooth_scan(a, b);
      MODE_TICK: if (idle_count < IDLE_TOP) idle_count++;
      MODE_LOCK: lock_state = 1'b1;
      default: ;
    endcase
  endfunction

  task automatic send_beat(input logic [MODE_W-1:0] code, input logic [ADC_BITS_DEF-1:0] a,
                           input logic [ADC_BITS_DEF-1:0] b);
    int unsigned gap;
    gap = tx_gapless ? 0 : $urandom_range(0, 12);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    mode <= code;
    pot_a <= a;
    pot_b <= b;
    do @(posedge clk); while (!in_ready);
    predict_beat(code, a, b);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_scans.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    store_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_noise(input logic [MODE_W-1:0] code);
    send_beat(code, ADC_BITS_DEF'($urandom_range(0, 1023)),
              ADC_BITS_DEF'($urandom_range(0, 1023)));
  endtask

  task automatic test_reset_state();
    send_beat(MODE_SCAN, 10'd0, 10'd0);
    send_beat(MODE_UNUSED, 10'd1023, 10'd1023);
    repeat (10) send_beat(MODE_SCAN, 10'd1023, 10'd1023);
    send_beat(MODE_LOCK, 10'd0, 10'd0);
    send_beat(MODE_SCAN, 10'd1023, 10'd1023);
    send_beat(MODE_TICK, 10'd1023, 10'd0);
    send_beat(MODE_SCAN, 10'd0, 10'd0);
  endtask

  task automatic test_register_extremes();
    drain();
    write_reg(REG_LOCK_TIME, 16'd0);
    write_reg(REG_UNLOCK_DELTA, 16'hFFFF);
    write_reg(REG_UPDATE_DELTA, 16'd0);
    write_reg(REG_NONE, 16'h0001);
    send_beat(MODE_TICK, 10'd0, 10'd0);
    send_beat(MODE_SCAN, 10'd512, 10'd512);
    send_beat(MODE_SCAN, 10'd0, 10'd1023);
    drain();
    write_reg(REG_LOCK_TIME, 16'hFFFF);
    write_reg(REG_UNLOCK_DELTA, 16'd0);
    write_reg(REG_UPDATE_DELTA, 16'd1023);
    send_beat(MODE_LOCK, 10'd0, 10'd0);
    send_beat(MODE_SCAN, 10'd1023, 10'd0);
    send_beat(MODE_SCAN, 10'd1023, 10'd0);
  endtask

  task automatic test_reverse_offsets();
    drain();
    write_reg(REG_UNLOCK_DELTA, 16'd30);
    write_reg(REG_UPDATE_DELTA, 16'd3);
    write_reg(REG_REV_OFS_A, 16'd1023);
    write_reg(REG_REV_OFS_B, 16'd1);
    send_beat(MODE_SCAN, 10'd0, 10'd1023);
    send_beat(MODE_SCAN, 10'd1023, 10'd0);
    send_beat(MODE_SCAN, 10'd1, 10'd1);
    drain();
    write_reg(REG_REV_OFS_A, 16'hFC00);
    write_reg(REG_REV_OFS_B, 16'd512);
    send_beat(MODE_SCAN, 10'd700, 10'd100);
  endtask

  task automatic test_stall_pressure();
    drain();
    write_reg(REG_UNLOCK_DELTA, 16'd30);
    write_reg(REG_UPDATE_DELTA, 16'd0);
    rx_hold = 300;
    tx_gapless = 1'b1;
    repeat (40) send_noise(MODE_SCAN);
    tx_gapless = 1'b0;
  endtask

  task automatic test_random_traffic();
    logic [LOCK_W-1:0] lock_opts [6];
    logic [DLT_W-1:0] unlock_opts [4];
    logic [DLT_W-1:0] update_opts [4];
    int walk_a;
    int walk_b;
    int sent;
    int pick;
    int burst;
    lock_opts = '{16'd0, 16'd1, 16'd20, 16'd300, 16'd5000, 16'hFFFF};
    unlock_opts = '{10'd0, 10'd1023, 10'd30, 10'd8};
    update_opts = '{10'd0, 10'd1023, 10'd3, 10'd12};
    walk_a = 512;
    walk_b = 512;
    for (int p = 0; p < 9; p++) begin
      drain();
      write_reg(REG_LOCK_TIME, lock_opts[p % 6]);
      write_reg(REG_UNLOCK_DELTA, DATA_W'(unlock_opts[p % 4]));
      write_reg(REG_UPDATE_DELTA, DATA_W'(update_opts[(p + 2) % 4]));
      write_reg(REG_REV_OFS_A, (p % 3 == 0) ? 16'd0 :
                (p % 3 == 1) ? DATA_W'($urandom_range(0, 1023)) : 16'd1023);
      write_reg(REG_REV_OFS_B, (p % 3 == 2) ? 16'd0 : DATA_W'($urandom()));
      sent = 0;
      while (sent < 200) begin
        if (sent % 50 == 0) begin
          tx_gapless = ($urandom_range(0, 2) == 0);
          rx_gapless = ($urandom_range(0, 2) == 0);
        end
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          // slow drift with the odd jump, as a hand turns the knob
          if (pick < 5) begin
            walk_a = $urandom_range(0, 1023);
            walk_b = $urandom_range(0, 1023);
          end else begin
            walk_a += int'($urandom_range(0, 8)) - 4;
            walk_b += int'($urandom_range(0, 8)) - 4;
          end
          walk_a = (walk_a < 0) ? 0 : (walk_a > 1023) ? 1023 : walk_a;
          walk_b = (walk_b < 0) ? 0 : (walk_b > 1023) ? 1023 : walk_b;
          send_beat(MODE_SCAN, ADC_BITS_DEF'(walk_a), ADC_BITS_DEF'(walk_b));
          sent++;
        end else if (pick < 85) begin
          burst = $urandom_range(1, 30);
          repeat (burst) send_noise(MODE_TICK);
          sent += burst;
        end else if (pick < 90) begin
          send_noise(MODE_LOCK);
          sent++;
        end else if (pick < 93) begin
          send_noise(MODE_UNUSED);
        end else begin
          send_noise(MODE_SCAN);
          sent++;
        end
      end
    end
    tx_gapless = 1'b0;
    rx_gapless = 1'b0;
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    scan_levels_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_scans.size() == 0) begin
        $error("result beat with no scan pending");
        mismatches++;
      end else begin
        want = expected_scans.pop_front();
        check_field("led_written", want.written, led_written);
        check_field("cold_level", want.cold, cold_level);
        check_field("warm_level", want.warm, warm_level);
        check_field("brightness", want.bright, brightness);
        check_field("is_locked", want.locked, is_locked);
        check_field("avg_a", want.mean_a, avg_a);
        check_field("avg_b", want.mean_b, avg_b);
      end
    end
  end

  // result side: random stalls, plus one long hold when asked
  initial begin
    int unsigned gap;
    out_ready = 1'b0;
    @(negedge clk iff !rst);
    forever begin
      if (rx_hold != 0) begin
        gap = rx_hold;
        rx_hold = 0;
      end else begin
        gap = rx_gapless ? 0 : $urandom_range(0, 12);
      end
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("pot_smoothing_lock_led_mapper_top test failed");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    mode = MODE_SCAN;
    pot_a = '0;
    pot_b = '0;
    mismatches = 0;
    quiet_cycles = 0;
    tx_gapless = 1'b0;
    rx_gapless = 1'b0;
    rx_hold = 0;
    reset_model();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_register_extremes();
    test_reverse_offsets();
    test_stall_pressure();
    test_random_traffic();
    drain();
    if (mismatches == 0)
      $display("pot_smoothing_lock_led_mapper_top test passed");
    else
      $display("pot_smoothing_lock_led_mapper_top test failed");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/psl_pkg.sv
hw/rtl/psl_ram.sv
hw/rtl/psl_core.sv
hw/rtl/psl_map.sv
hw/rtl/pot_smoothing_lock_led_mapper_top.sv
bench/testbench.sv
